@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tilt-angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ATA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define ATA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles, held off during reset.
`define ATA_ASSERT_DLY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

@@ rtl/ata_pkg.sv @@
// Types, constants and the arctangent table for the tilt-angle pipeline.
package ata_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int CORDIC_STEPS_DEF    = 16;

	localparam int ACC_FRAC  = 16;            // accumulator in 2^-16 degree
	localparam int TABLE_LEN = 24;
	localparam int TIDX_W    = $clog2(TABLE_LEN);
	localparam int NUM_LANES = 3;
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	localparam int SAMPLE_W = 16;
	localparam int ANGLE_W  = 16;
	localparam int OPD_W    = SAMPLE_W + 1;   // holds -(-32768)
	localparam int PRE_SHIFT = 8;             // operands scaled by 256
	localparam int W_XY = OPD_W + PRE_SHIFT + 2;
	localparam int W_Z  = 27;

	localparam logic signed [W_Z-1:0] DEG90  = W_Z'(90 * 65536);
	localparam logic signed [W_Z-1:0] DEG180 = W_Z'(180 * 65536);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} in_word_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] roll_angle;
		logic [ANGLE_W-1:0] pitch_angle;
		logic [ANGLE_W-1:0] yaw_angle;
	} out_word_t;

	// one arctangent in flight; fix marks an angle settled before rotation
	typedef struct packed {
		logic signed [W_XY-1:0] x;
		logic signed [W_XY-1:0] y;
		logic signed [W_Z-1:0]  z;
		logic                   fix;
	} lane_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic signed [W_Z-1:0] atan_lut(input logic [TIDX_W-1:0] idx);
		logic signed [W_Z-1:0] v;
		case (idx)
			5'd0:    v = W_Z'(2949120);
			5'd1:    v = W_Z'(1740967);
			5'd2:    v = W_Z'(919879);
			5'd3:    v = W_Z'(466945);
			5'd4:    v = W_Z'(234379);
			5'd5:    v = W_Z'(117304);
			5'd6:    v = W_Z'(58666);
			5'd7:    v = W_Z'(29335);
			5'd8:    v = W_Z'(14668);
			5'd9:    v = W_Z'(7334);
			5'd10:   v = W_Z'(3667);
			5'd11:   v = W_Z'(1833);
			5'd12:   v = W_Z'(917);
			5'd13:   v = W_Z'(458);
			5'd14:   v = W_Z'(229);
			5'd15:   v = W_Z'(115);
			5'd16:   v = W_Z'(57);
			5'd17:   v = W_Z'(29);
			5'd18:   v = W_Z'(14);
			5'd19:   v = W_Z'(7);
			5'd20:   v = W_Z'(4);
			5'd21:   v = W_Z'(2);
			5'd22:   v = W_Z'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/ata_prep.sv @@
// Input stage: operand selection, quadrant folding and special angles.
`include "assert_macros.svh"

module ata_prep (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        take,
	input  ata_pkg::in_word_t                           sample,
	output logic                                        vld,
	output ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]     lanes
);

	localparam int XW = ata_pkg::W_XY;
	localparam int OW = ata_pkg::OPD_W;

	logic signed [OW-1:0] ax, ay, az, nx;
	ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0] lanes_d;
	ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0] lanes_s1;
	logic vld_s1;

	// atan2(num, den) start point; left half-plane folded by 180 deg
	function automatic ata_pkg::lane_t setup(input logic signed [OW-1:0] num,
		input logic signed [OW-1:0] den);
		ata_pkg::lane_t l;
		l = '0;
		if (num == '0) begin
			l.fix = 1'b1;
			l.z   = (den < 0) ? ata_pkg::DEG180 : '0;
		end else if (den == '0) begin
			l.fix = 1'b1;
			l.z   = (num > 0) ? ata_pkg::DEG90 : -ata_pkg::DEG90;
		end else if (den > 0) begin
			l.x = XW'(den) <<< ata_pkg::PRE_SHIFT;
			l.y = XW'(num) <<< ata_pkg::PRE_SHIFT;
		end else begin
			l.x = (-XW'(den)) <<< ata_pkg::PRE_SHIFT;
			l.y = (-XW'(num)) <<< ata_pkg::PRE_SHIFT;
			l.z = (num > 0) ? ata_pkg::DEG180 : -ata_pkg::DEG180;
		end
		return l;
	endfunction

	always_comb begin
		ax = OW'(sample.accel_x);
		ay = OW'(sample.accel_y);
		az = OW'(sample.accel_z);
		nx = -ax;
		lanes_d[ata_pkg::LANE_ROLL]  = setup(az, nx);
		lanes_d[ata_pkg::LANE_PITCH] = setup(az, ay);
		lanes_d[ata_pkg::LANE_YAW]   = setup(nx, ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		lanes_s1 <= lanes_d;
	end

	assign vld   = vld_s1;
	assign lanes = lanes_s1;

	// a rotating lane always starts in the right half-plane
	`ATA_ASSERT_IMP(a_prep_right_half, vld_s1 && !lanes_s1[0].fix, lanes_s1[0].x > 0, "roll lane starts with x <= 0")

endmodule

@@ rtl/ata_stage.sv @@
// One CORDIC vectoring micro-rotation for all three lanes.
`include "assert_macros.svh"

module ata_stage #(
	parameter int STEP = 0
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        prev_vld,
	input  ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]     prev_lanes,
	output logic                                        vld,
	output ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]     lanes
);

	localparam int TW = ata_pkg::TIDX_W;
	localparam logic signed [ata_pkg::W_Z-1:0] ANG = ata_pkg::atan_lut(TW'(STEP));

	ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0] nxt;
	ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0] lanes_s1;
	logic vld_s1;

	always_comb begin
		for (int k = 0; k < ata_pkg::NUM_LANES; k++) begin
			nxt[k] = prev_lanes[k];
			if (!prev_lanes[k].fix) begin
				if ($signed(prev_lanes[k].y) > 0) begin
					nxt[k].x = prev_lanes[k].x + ($signed(prev_lanes[k].y) >>> STEP);
					nxt[k].y = prev_lanes[k].y - ($signed(prev_lanes[k].x) >>> STEP);
					nxt[k].z = prev_lanes[k].z + ANG;
				end else begin
					nxt[k].x = prev_lanes[k].x - ($signed(prev_lanes[k].y) >>> STEP);
					nxt[k].y = prev_lanes[k].y + ($signed(prev_lanes[k].x) >>> STEP);
					nxt[k].z = prev_lanes[k].z - ANG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		lanes_s1 <= nxt;
	end

	assign vld   = vld_s1;
	assign lanes = lanes_s1;

	// settled angles pass untouched
	for (genvar g = 0; g < ata_pkg::NUM_LANES; g++) begin : g_chk
		`ATA_ASSERT_NXT(a_fix_hold, prev_vld && prev_lanes[g].fix, lanes_s1[g].fix && lanes_s1[g].z == $past(prev_lanes[g].z), "settled angle changed in rotation")
	end

endmodule

@@ rtl/ata_round.sv @@
// Output stages: clamp to +-180 deg, offset, round to output units.
`include "assert_macros.svh"

module ata_round #(
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        prev_vld,
	input  ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]     prev_lanes,
	output logic                                        vld,
	output ata_pkg::out_word_t                          word
);

	localparam int ZW = ata_pkg::W_Z;
	localparam int SH = ata_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ZW-1:0] HALF = ZW'(1 << (SH - 1));
	localparam logic [ZW-1:0] TOP  = ZW'(360 << ANGLE_FRAC_BITS);
	localparam logic [ZW-1:0] FULL = ZW'(2 * 180 * 65536);

	logic signed [ZW-1:0] zc [ata_pkg::NUM_LANES];
	logic [ZW-1:0] tot_d [ata_pkg::NUM_LANES];
	logic [ZW-1:0] tot_s1 [ata_pkg::NUM_LANES];
	logic [ZW-1:0] rnd [ata_pkg::NUM_LANES];
	logic [ata_pkg::ANGLE_W-1:0] fld [ata_pkg::NUM_LANES];
	ata_pkg::out_word_t word_s2;
	logic vld_s1, vld_s2;

	always_comb begin
		for (int k = 0; k < ata_pkg::NUM_LANES; k++) begin
			if ($signed(prev_lanes[k].z) > ata_pkg::DEG180) begin
				zc[k] = ata_pkg::DEG180;
			end else if ($signed(prev_lanes[k].z) < -ata_pkg::DEG180) begin
				zc[k] = -ata_pkg::DEG180;
			end else begin
				zc[k] = prev_lanes[k].z;
			end
			tot_d[k] = zc[k] + ata_pkg::DEG180;
		end
	end

	always_comb begin
		for (int k = 0; k < ata_pkg::NUM_LANES; k++) begin
			rnd[k] = (tot_s1[k] + HALF) >> SH;
			if (rnd[k] > TOP) begin
				rnd[k] = TOP;
			end
			fld[k] = rnd[k][ata_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= prev_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tot_s1 <= tot_d;
		word_s2.roll_angle  <= fld[ata_pkg::LANE_ROLL];
		word_s2.pitch_angle <= fld[ata_pkg::LANE_PITCH];
		word_s2.yaw_angle   <= fld[ata_pkg::LANE_YAW];
	end

	assign vld  = vld_s2;
	assign word = word_s2;

	// clamp and offset keep every total within 0..360 deg
	`ATA_ASSERT_IMP(a_total_range, vld_s1, tot_s1[0] <= FULL && tot_s1[1] <= FULL && tot_s1[2] <= FULL, "offset angle beyond 360 deg")

endmodule

@@ rtl/accel_tilt_angles.sv @@
// Top level of the accelerometer tilt-angle pipeline.
// Tilt angles from one three-axis accelerometer sample: roll = atan2(z,-x),
// pitch = atan2(z,y) and yaw = atan2(-x,y), each shifted by +180 deg and
// given unsigned in units of 2^-ANGLE_FRAC_BITS degree (0 to 360 deg).
// A word is taken whenever start is high; busy is always low, so a new
// sample may follow in every cycle. Each sample gives exactly one result
// word, shown for one cycle with done high, after it has passed through
// the rotation pipeline: one input stage, one register stage per CORDIC
// micro-rotation, and two stages to clamp and round. The receiver cannot
// hold results off, so there is no back-pressure anywhere in the pipe.
`include "assert_macros.svh"

module accel_tilt_angles #(
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = ata_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ata_pkg::in_word_t   sample,
	output logic                done,
	output ata_pkg::out_word_t  result
);

	localparam int LATENCY = CORDIC_STEPS + 3;

	// valid and lanes per pipeline stage; index 0 is the input stage
	logic [CORDIC_STEPS:0] vld_s;
	ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0] lanes_s [CORDIC_STEPS+1];
	logic take;

	// the pipe never stalls, so every start is accepted
	assign busy = 1'b0;
	assign take = start && !busy;

	// operand choice and quadrant folding for the three arctangents
	ata_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (sample),
		.vld    (vld_s[0]),
		.lanes  (lanes_s[0])
	);

	// one micro-rotation per stage, angle table entry fixed per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		ata_stage #(
			.STEP (i)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_vld   (vld_s[i]),
			.prev_lanes (lanes_s[i]),
			.vld        (vld_s[i+1]),
			.lanes      (lanes_s[i+1])
		);
	end

	// clamp, +180 deg offset and rounding into the result word
	ata_round #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_vld   (vld_s[CORDIC_STEPS]),
		.prev_lanes (lanes_s[CORDIC_STEPS]),
		.vld        (done),
		.word       (result)
	);

	// every accepted sample comes out after the fixed latency
	`ATA_ASSERT_DLY(a_latency, take, LATENCY, done, "result word missing after pipeline latency")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the accelerometer tilt-angle pipeline.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Build of the block under test: defaults, spelt out here so that the
	// predictor below is tied to the same numbers.
	localparam int FRAC_BITS = 7;
	localparam int STEPS     = 16;
	localparam int LATENCY   = STEPS + 3;

	localparam int ACC_BITS    = 16;          // predictor angle in 2^-16 deg
	localparam int N_RANDOM    = 1050;
	localparam int QUIET_LIMIT = 2000;        // cycles with no word moving

	localparam longint HALF_TURN    = longint'(180) << ACC_BITS;
	localparam longint QUARTER_TURN = longint'(90) << ACC_BITS;

	// atan(2^-i) in 2^-16 degree
	localparam longint ATAN_STEP [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// a pending sample and how often the sender sits idle before offering it
	typedef struct {
		ata_pkg::in_word_t word;
		int unsigned       idle_pct;
	} sample_slot_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	ata_pkg::in_word_t  sample = '0;
	logic               done;
	ata_pkg::out_word_t result;

	sample_slot_t       sample_q[$];          // words still to be offered
	ata_pkg::out_word_t angle_q[$];           // predicted angles, oldest first
	sample_slot_t       next_slot;
	ata_pkg::out_word_t due_angles;

	logic word_taken   = 1'b0;                // start/!busy seen at last edge
	int   quiet_cycles = 0;
	int   n_taken      = 0;
	int   n_err        = 0;
	int   n_total;
	bit   timed_out    = 1'b0;

	accel_tilt_angles #(
		.ANGLE_FRAC_BITS(FRAC_BITS),
		.CORDIC_STEPS(STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Four-quadrant arctangent by vectoring CORDIC, in 2^-16 degree.
	// Operands are scaled by 256 before the micro-rotations; a negative
	// denominator is folded into the right half-plane with a +-180 deg start.
	function automatic longint cordic_atan2(input longint num, input longint den);
		longint x, y, z, nx;
		int     i;
		if (num == 0)
			return (den < 0) ? HALF_TURN : 0;
		if (den == 0)
			return (num > 0) ? QUARTER_TURN : -QUARTER_TURN;
		if (den > 0) begin
			x = den * 256;
			y = num * 256;
			z = 0;
		end else begin
			x = -den * 256;
			y = -num * 256;
			z = (num > 0) ? HALF_TURN : -HALF_TURN;
		end
		for (i = 0; i < STEPS && i < 24; i++) begin
			// arithmetic shift of a signed longint rounds towards minus infinity
			if (y > 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_STEP[i];
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_STEP[i];
			end
			x = nx;
		end
		// residue may overshoot half a turn near the negative real axis
		if (z > HALF_TURN)
			z = HALF_TURN;
		if (z < -HALF_TURN)
			z = -HALF_TURN;
		return z;
	endfunction

	// +180 deg, round half up to output units, clamp at 360 deg, keep 16 bits
	function automatic logic [15:0] angle_field(input longint ang);
		int     frac, sh;
		longint r;
		frac = (FRAC_BITS > ACC_BITS) ? ACC_BITS : FRAC_BITS;
		sh   = ACC_BITS - frac;
		r    = ang + HALF_TURN;
		if (sh > 0)
			r = (r + (longint'(1) << (sh - 1))) >>> sh;
		if (r > (longint'(360) << frac))
			r = longint'(360) << frac;
		return r[15:0];
	endfunction

	// roll = atan2(z,-x), pitch = atan2(z,y), yaw = atan2(-x,y); the negated
	// x is held in a longint so -(-32768) does not wrap
	function automatic ata_pkg::out_word_t tilt_angles(input ata_pkg::in_word_t w);
		longint             ax, ay, az;
		ata_pkg::out_word_t a;
		ax = longint'($signed(w.accel_x));
		ay = longint'($signed(w.accel_y));
		az = longint'($signed(w.accel_z));
		a.roll_angle  = angle_field(cordic_atan2(az, -ax));
		a.pitch_angle = angle_field(cordic_atan2(az, ay));
		a.yaw_angle   = angle_field(cordic_atan2(-ax, ay));
		return a;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	task automatic queue_sample(input int x, input int y, input int z,
			input int unsigned idle);
		sample_slot_t s;
		s.word.accel_x = 16'(x);
		s.word.accel_y = 16'(y);
		s.word.accel_z = 16'(z);
		s.idle_pct     = idle;
		sample_q.push_back(s);
	endtask

	// Axis value: mostly full range, with a fair share of zeros, rails and
	// small magnitudes so the special cases keep turning up.
	function automatic logic [15:0] rand_axis();
		case ($urandom_range(9))
			0:       return 16'd0;
			1: begin
				case ($urandom_range(3))
					0:       return 16'h8000;
					1:       return 16'h7fff;
					2:       return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			2, 3:    return 16'($urandom_range(127)) - 16'd64;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic check_angle(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			n_err++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: offers the next word at the falling edge once the previous one
	// has gone in; junk sits on the sample bus while start is low.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= sample_q[0].idle_pct) begin
				next_slot = sample_q.pop_front();
				start  <= 1'b1;
				sample <= next_slot.word;
			end else begin
				start  <= 1'b0;
				sample <= ata_pkg::in_word_t'(48'({$urandom(), $urandom()}));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: takes accepted words and results at the rising edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			word_taken <= start && !busy;
			if (start && !busy) begin
				angle_q.push_back(tilt_angles(sample));
				n_taken++;
			end
			if (done) begin
				if (angle_q.size() == 0) begin
					$display("%0t: result word with none due, got roll %0d pitch %0d yaw %0d",
						$time, result.roll_angle, result.pitch_angle, result.yaw_angle);
					n_err++;
				end else begin
					due_angles = angle_q.pop_front();
					check_angle("roll_angle", due_angles.roll_angle, result.roll_angle);
					check_angle("pitch_angle", due_angles.pitch_angle, result.pitch_angle);
					check_angle("yaw_angle", due_angles.yaw_angle, result.yaw_angle);
				end
			end
			// watchdog: any word moving either way resets the count
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		// Directed words, sender idling about a third of the time.
		queue_sample(0, 0, 0, 34);              // atan2(0,0) everywhere: 180 deg
		queue_sample(0, 0, 100, 34);            // zero denominators, +90
		queue_sample(0, 0, -100, 34);           // zero denominators, -90
		queue_sample(100, 0, 0, 34);            // roll: zero over negative -> 360
		queue_sample(-100, 0, 0, 34);           // roll: zero over positive -> 180
		queue_sample(0, 100, 0, 34);
		queue_sample(0, -100, 0, 34);           // pitch and yaw -> 360
		queue_sample(32767, 32767, 32767, 34);
		queue_sample(-32768, -32768, -32768, 34);
		queue_sample(32767, -32768, 32767, 34);
		queue_sample(-32768, 32767, -32768, 34);
		queue_sample(-32768, 0, 0, 34);         // -x = +32768
		queue_sample(-32768, 0, 1, 34);
		queue_sample(-32768, -1, 0, 34);
		queue_sample(32767, 0, 1, 34);          // near the negative real axis:
		queue_sample(32767, 0, -1, 34);         // residue may pass +-180
		queue_sample(0, -32768, 1, 34);
		queue_sample(0, -32768, -1, 34);
		queue_sample(1, -32768, 0, 34);
		queue_sample(-1, -32768, 0, 34);
		queue_sample(1, 1, 1, 34);
		queue_sample(-1, -1, -1, 34);
		queue_sample(1, -1, 0, 34);

		// Random words in three stretches: light idling, heavy idling, none.
		for (int i = 0; i < N_RANDOM; i++)
			queue_sample($signed(rand_axis()), $signed(rand_axis()), $signed(rand_axis()),
				(i < N_RANDOM / 3) ? 34 : (i < 2 * N_RANDOM / 3) ? 65 : 0);
		n_total = sample_q.size();

		// Reset once, released on a falling edge.
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every word to go in and every result to come back.
		while (!timed_out && (n_taken < n_total || angle_q.size() != 0)) begin
			@(negedge clk);
			timed_out = quiet_cycles >= QUIET_LIMIT;
		end
		// Drain: anything that still pops out now has no expectation.
		if (!timed_out)
			repeat (2 * LATENCY) @(negedge clk);

		if (timed_out)
			$display("%0t: watchdog, %0d quiet cycles, %0d of %0d taken, %0d results due",
				$time, quiet_cycles, n_taken, n_total, angle_q.size());
		if (!timed_out && n_err == 0)
			$display("** accel_tilt_angles: PASSED **");
		else
			$display("** accel_tilt_angles: FAILED **");
		$finish;
	end

endmodule
